// File: design/assert_macros.svh
// Assertion macros for the salted password hash unit.
// Used by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property at every clock edge outside reset.
`define SPH_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("sph assertion failed");

// Check that a condition implies another one at the next clock edge.
`define SPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sph assertion failed");

`else

`define SPH_ASSERT(lbl, clk, rst_n, prop)
`define SPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: design/sph_pkg.sv
// Package for the salted password hash unit: payload types, command struct,
// register indexes and default sizes. No dependencies.
`timescale 1ns / 1ps

package sph_pkg;

	localparam int CHAR_W     = 7;
	localparam int HASH_W     = 32;
	localparam int HASH_SHIFT = 4;   // multiply by 17 = shift by 4 plus one
	localparam int REG_IDX_W  = 1;

	localparam int MAX_CHARS_DEF = 32;
	localparam int ROUNDS_DEF    = 16;

	localparam logic [REG_IDX_W-1:0] REG_SALT     = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_EXPECTED = 1'b1;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} sph_in_t;

	typedef struct packed {
		logic [HASH_W-1:0] hash_value;
		logic              matches_res;
		logic              too_long;
	} sph_res_t;

	typedef struct packed {
		logic wr_en;     // store the incoming character
		logic rd_en;     // fetch a buffered character
		logic init;      // load the hash with the salt
		logic fold;      // hash = hash*17 + fetched character
		logic mix;       // hash ^= salt
		logic finish;    // final mix into the result register
		logic too_long;  // dropped-character flag for the result
	} sph_cmd_t;

endpackage

// File: design/sph_dp.sv
// Datapath of the salted password hash unit: config registers, character
// buffer, hash accumulator and result register. Depends on sph_pkg.
`timescale 1ns / 1ps

module sph_dp #(
	parameter int MAX_CHARS = sph_pkg::MAX_CHARS_DEF,
	localparam int IDX_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [sph_pkg::REG_IDX_W-1:0]    cfg_idx,
	input  logic [sph_pkg::HASH_W-1:0]       cfg_data,
	input  sph_pkg::sph_cmd_t                cmd,
	input  logic [IDX_W-1:0]                 wr_addr,
	input  logic [IDX_W-1:0]                 rd_addr,
	input  logic [sph_pkg::CHAR_W-1:0]       wr_char,
	output sph_pkg::sph_res_t                result
);

	logic [sph_pkg::HASH_W-1:0] salt_q;
	logic [sph_pkg::HASH_W-1:0] expected_q;
	logic [sph_pkg::CHAR_W-1:0] buf_mem [MAX_CHARS];
	logic [sph_pkg::CHAR_W-1:0] rdata_q;
	logic [sph_pkg::HASH_W-1:0] hash_q;
	logic [sph_pkg::HASH_W-1:0] mixed;
	sph_pkg::sph_res_t          result_q;

	assign mixed  = hash_q ^ salt_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			salt_q     <= '0;
			expected_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				sph_pkg::REG_SALT:     salt_q     <= cfg_data;
				sph_pkg::REG_EXPECTED: expected_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			buf_mem[wr_addr] <= wr_char;
		end
		if (cmd.rd_en) begin
			rdata_q <= buf_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			hash_q <= salt_q;
		end else if (cmd.fold) begin
			hash_q <= (hash_q << sph_pkg::HASH_SHIFT) + hash_q
				+ sph_pkg::HASH_W'(rdata_q);
		end else if (cmd.mix) begin
			hash_q <= mixed;
		end
		if (cmd.finish) begin
			result_q.hash_value  <= mixed;
			result_q.matches_res <= (mixed == expected_q);
			result_q.too_long    <= cmd.too_long;
		end
	end

endmodule

// File: design/sph_ctrl.sv
// Controller of the salted password hash unit: character intake, round and
// character sequencing, output handshake. Depends on sph_pkg.
`timescale 1ns / 1ps

module sph_ctrl #(
	parameter int MAX_CHARS = sph_pkg::MAX_CHARS_DEF,
	parameter int ROUNDS    = sph_pkg::ROUNDS_DEF,
	localparam int IDX_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [sph_pkg::CHAR_W-1:0]   in_char,
	input  logic                         in_last,
	output logic                         out_valid,
	input  logic                         out_ready,
	output sph_pkg::sph_cmd_t            cmd,
	output logic [IDX_W-1:0]             wr_addr,
	output logic [IDX_W-1:0]             rd_addr
);

	localparam int CNT_W = $clog2(MAX_CHARS + 1);
	localparam int RND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

	typedef enum logic [1:0] {
		S_LOAD,
		S_PRIME,
		S_FOLD,
		S_MIX
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic             term_q;
	logic             ovf_q;
	logic [IDX_W-1:0] idx_q;
	logic [RND_W-1:0] round_q;
	logic             out_valid_q;

	logic take;
	logic full;
	logic last_char;
	logic last_round;
	logic out_free;

	assign in_ready   = (state_q == S_LOAD);
	assign out_valid  = out_valid_q;
	assign take       = in_valid && in_ready;
	assign full       = (count_q == CNT_W'(MAX_CHARS));
	assign last_char  = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign last_round = (round_q == RND_W'(ROUNDS - 1));
	assign out_free   = !out_valid_q || out_ready;
	assign wr_addr    = count_q[IDX_W-1:0];
	assign rd_addr    = (state_q == S_FOLD) ? idx_q + IDX_W'(1) : '0;

	always_comb begin
		cmd          = '0;
		cmd.wr_en    = take && !term_q && (in_char != '0) && !full;
		cmd.rd_en    = (state_q == S_PRIME)
			|| (state_q == S_MIX && !last_round)
			|| (state_q == S_FOLD && !last_char);
		cmd.init     = (state_q == S_PRIME);
		cmd.fold     = (state_q == S_FOLD);
		cmd.mix      = (state_q == S_MIX) && (!last_round || out_free);
		cmd.finish   = (state_q == S_MIX) && last_round && out_free;
		cmd.too_long = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			count_q     <= '0;
			term_q      <= 1'b0;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// raise on a finished hash, drop once the receiver takes it
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (take) begin
						if (!term_q) begin
							if (in_char == '0) begin
								term_q <= 1'b1;
							end else if (full) begin
								ovf_q <= 1'b1;
							end else begin
								count_q <= count_q + CNT_W'(1);
							end
						end
						if (in_last) begin
							state_q <= S_PRIME;
						end
					end
				end
				S_PRIME: begin
					round_q <= '0;
					idx_q   <= '0;
					state_q <= (count_q == '0) ? S_MIX : S_FOLD;
				end
				S_FOLD: begin
					if (last_char) begin
						state_q <= S_MIX;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_MIX: begin
					if (!last_round) begin
						round_q <= round_q + RND_W'(1);
						idx_q   <= '0;
						state_q <= (count_q == '0) ? S_MIX : S_FOLD;
					end else if (out_free) begin
						count_q     <= '0;
						term_q      <= 1'b0;
						ovf_q       <= 1'b0;
						state_q     <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

// File: design/salted_password_hash_unit.sv
// Salted password hash unit, top level: ties the controller to the datapath.
// Depends on sph_pkg, sph_ctrl, sph_dp and assert_macros.svh.
//
// Usage: send the password one request per character on in_valid/in_ready
// (in_data.character, in_data.last), back to back while in_ready is high.
// A zero character ends the string; later characters are ignored. Characters
// past MAX_CHARS are dropped and reported as too_long. The request with
// last set starts hashing: the hash is seeded with salt, and each of ROUNDS
// rounds folds every stored character (hash*17 + char) and XORs the salt in.
// After the last request the hash is seeded; each round then folds one stored
// character per cycle through the single buffer read port and ends with one
// salt mix. in_ready stays low while hashing. The result sits in an output
// register, so new characters are accepted while it waits; if the receiver
// stalls, the next hash holds in its final mix step until the register is
// free. Configure salt (index 0) and expected_hash (index 1) through cfg_wr_en/cfg_idx/
// cfg_data while idle. Reset clears both registers, the character count and
// the control flags; the buffer, hash and result registers are not
// cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module salted_password_hash_unit #(
	parameter int MAX_CHARS = sph_pkg::MAX_CHARS_DEF,
	parameter int ROUNDS    = sph_pkg::ROUNDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  sph_pkg::sph_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output sph_pkg::sph_res_t             out_data,
	input  logic                          cfg_wr_en,
	input  logic [sph_pkg::REG_IDX_W-1:0] cfg_idx,
	input  logic [sph_pkg::HASH_W-1:0]    cfg_data
);

	localparam int IDX_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

	// command bundle from the sequencer to the datapath
	sph_pkg::sph_cmd_t cmd;
	logic [IDX_W-1:0]  wr_addr;
	logic [IDX_W-1:0]  rd_addr;

	// controller: intake, round/character sequencing, output handshake
	sph_ctrl #(
		.MAX_CHARS (MAX_CHARS),
		.ROUNDS    (ROUNDS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_char   (in_data.character),
		.in_last   (in_data.last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr)
	);

	// datapath: buffer memory, hash register, config and result registers
	sph_dp #(
		.MAX_CHARS (MAX_CHARS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.wr_char   (in_data.character),
		.result    (out_data)
	);

	// buffer writes happen only on an accepted request
	`SPH_ASSERT(a_wr_on_accept, clk, arst_n, !cmd.wr_en || (in_valid && in_ready))
	// a finished request blocks intake while hashing
	`SPH_ASSERT_NEXT(a_busy_after_last, clk, arst_n, in_valid && in_ready && in_data.last, !in_ready)
	// never overwrite a result the receiver has not taken
	`SPH_ASSERT(a_no_overwrite, clk, arst_n, !cmd.finish || !out_valid || out_ready)
	// datapath steps are mutually exclusive
	`SPH_ASSERT(a_one_step, clk, arst_n, $onehot0({cmd.init, cmd.fold, cmd.mix}))

endmodule
